@@ sv/gcd_pkg.sv @@
// Package for the great-circle distance block: shared types, constants and table functions.
`default_nettype none

package gcd_pkg;

    // Pi in Q62 and the half-milliarcsecond count of a half turn.
    localparam logic [63:0] PI_Q62         = 64'hC90F_DAA2_2168_C235;
    localparam logic [63:0] HALFMAS_PER_PI = 64'd1296000000;
    localparam logic [63:0] HALFMAS_HALF   = 64'd648000000;

    // Radians per half-milliarcsecond in Q62, rounded.
    localparam logic [63:0] RAD_PER_HALFMAS_Q62 =
        (PI_Q62 + 64'd648000000) / 64'd1296000000;

    // Pi/2 in Q40, rounded.
    localparam logic [40:0] HALF_PI_Q40 = 41'((PI_Q62 + (64'd1 << 22)) >> 23);

    localparam logic [60:0] ONE_Q60       = 61'd1 << 60;
    localparam logic [22:0] RADIUS_RESET  = 23'd6371000;

    localparam int ANGLE_W = 44;
    localparam int ATAN_TERMS = 32;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] x;
        logic signed [ANGLE_W-1:0] y;
        logic signed [ANGLE_W-1:0] z;
    } cordic_t;

    typedef struct packed {
        logic [61:0] val;
        logic [33:0] rem;
        logic [30:0] root;
    } sqrt_t;

    // Divides by the odd number 2k+1, one fixed divisor per arm.
    function automatic logic [63:0] odd_div(input logic [63:0] x, input int k);
        logic [63:0] q;
        case (k)
            0:  q = x / 1;    1:  q = x / 3;    2:  q = x / 5;    3:  q = x / 7;
            4:  q = x / 9;    5:  q = x / 11;   6:  q = x / 13;   7:  q = x / 15;
            8:  q = x / 17;   9:  q = x / 19;   10: q = x / 21;   11: q = x / 23;
            12: q = x / 25;   13: q = x / 27;   14: q = x / 29;   15: q = x / 31;
            16: q = x / 33;   17: q = x / 35;   18: q = x / 37;   19: q = x / 39;
            20: q = x / 41;   21: q = x / 43;   22: q = x / 45;   23: q = x / 47;
            24: q = x / 49;   25: q = x / 51;   26: q = x / 53;   27: q = x / 55;
            28: q = x / 57;   29: q = x / 59;   30: q = x / 61;
            default: q = x / 63;
        endcase
        return q;
    endfunction

    // atan(2^-i) in Q40, from its power series in Q62.
    function automatic logic [ANGLE_W-1:0] atan_q40(input int i);
        logic [63:0]        v;
        logic [63:0]        t;
        logic [63:0]        r;
        logic signed [63:0] acc;
        int                 e;
        acc = '0;
        v   = '0;
        if (i == 0) begin
            v = PI_Q62 >> 2;
        end else begin
            for (int k = 0; k < ATAN_TERMS; k++) begin
                e = 62 - i * (2 * k + 1);
                if (e >= 0) begin
                    t = odd_div(64'd1 << e, k);
                    if (k % 2 == 1) begin
                        acc = acc - $signed(t);
                    end else begin
                        acc = acc + $signed(t);
                    end
                end
            end
            v = 64'(acc);
        end
        r = (v + (64'd1 << 21)) >> 22;
        return r[ANGLE_W-1:0];
    endfunction

    // Square of the CORDIC gain in Q62.
    function automatic logic [63:0] cordic_gain_sq(input int n);
        logic [63:0] g2;
        g2 = 64'd1 << 62;
        for (int i = 0; i < 48; i++) begin
            if (i < n && 2 * i < 64) begin
                g2 = g2 + (g2 >> (2 * i));
            end
        end
        return g2;
    endfunction

    // Floor square root, evaluated on constants only.
    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bit_w;
        v     = v_in;
        res   = '0;
        bit_w = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (bit_w > v) begin
                bit_w = bit_w >> 2;
            end
        end
        for (int j = 0; j < 32; j++) begin
            if (bit_w != 0) begin
                if (v >= res + bit_w) begin
                    v   = v - (res + bit_w);
                    res = (res >> 1) + bit_w;
                end else begin
                    res = res >> 1;
                end
                bit_w = bit_w >> 2;
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ sv/gcd_sin_cell.sv @@
// One rotation-mode CORDIC cell of the sine chain.
`default_nettype none

module gcd_sin_cell #(
    parameter int IDX = 0
) (
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire gcd_pkg::cordic_t c_i,
    output gcd_pkg::cordic_t      c_o
);

    localparam logic signed [gcd_pkg::ANGLE_W-1:0] ATAN = gcd_pkg::atan_q40(IDX);

    logic signed [gcd_pkg::ANGLE_W-1:0] dx;
    logic signed [gcd_pkg::ANGLE_W-1:0] dy;
    gcd_pkg::cordic_t c_next;
    gcd_pkg::cordic_t c_reg;

    always_comb begin
        dx = c_i.y >>> IDX;
        dy = c_i.x >>> IDX;
        if (!c_i.z[gcd_pkg::ANGLE_W-1]) begin
            c_next.x = c_i.x - dx;
            c_next.y = c_i.y + dy;
            c_next.z = c_i.z - ATAN;
        end else begin
            c_next.x = c_i.x + dx;
            c_next.y = c_i.y - dy;
            c_next.z = c_i.z + ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_reg <= c_next;
        end
    end

    assign c_o = c_reg;

endmodule

`default_nettype wire

@@ sv/gcd_hav_lane.sv @@
// Haversine lane: angle reduction, sine chain and squaring for one angle.
`default_nettype none

module gcd_hav_lane #(
    parameter int STAGES = 32
) (
    input  wire logic               aclk,
    input  wire logic               en,
    input  wire logic signed [31:0] d_i,
    output logic [60:0]             hav_o
);

    localparam logic [63:0] GAIN_SQ = gcd_pkg::cordic_gain_sq(STAGES);
    localparam logic [63:0] GAIN    = gcd_pkg::isqrt64(GAIN_SQ);
    localparam logic [63:0] TWO63   = 64'h8000_0000_0000_0000;
    localparam logic [63:0] KINV    = ((TWO63 / GAIN) << 8) + (((TWO63 % GAIN) << 8) / GAIN);

    localparam logic [32:0] TWO_M  = 33'(2 * gcd_pkg::HALFMAS_PER_PI);
    localparam logic [31:0] ONE_M  = 32'(gcd_pkg::HALFMAS_PER_PI);
    localparam logic [30:0] HALF_M = 31'(gcd_pkg::HALFMAS_HALF);
    localparam logic [33:0] RAD_C  = 34'(gcd_pkg::RAD_PER_HALFMAS_Q62);

    logic [32:0] r0_reg;
    logic [31:0] r1_reg;
    logic [30:0] r2_reg;
    logic [29:0] fold_reg;
    logic [40:0] a_reg;
    logic [30:0] s30_reg;
    logic [60:0] hav_reg;

    logic [31:0] r1_next;
    logic [30:0] r2_next;
    logic [29:0] fold_next;
    logic [63:0] prod;
    logic [63:0] prod_rnd;
    logic [30:0] s30_next;
    logic [gcd_pkg::ANGLE_W-1:0] s_rnd;

    gcd_pkg::cordic_t chain [STAGES+1];

    always_comb begin
        r1_next   = (r0_reg >= TWO_M) ? 32'(r0_reg - TWO_M) : 32'(r0_reg);
        r2_next   = (r1_reg >= ONE_M) ? 31'(r1_reg - ONE_M) : 31'(r1_reg);
        fold_next = (r2_reg > HALF_M) ? 30'(31'(ONE_M) - r2_reg) : 30'(r2_reg);
        prod      = 64'(fold_reg) * 64'(RAD_C);
        prod_rnd  = prod + (64'd1 << 21);
    end

    // Sine is clamped at zero, rounded to Q30 and clamped at one.
    always_comb begin
        s_rnd    = chain[STAGES].y + 44'sd512;
        s30_next = '0;
        if (!chain[STAGES].y[gcd_pkg::ANGLE_W-1]) begin
            if (s_rnd[gcd_pkg::ANGLE_W-1:10] > 34'(31'd1 << 30)) begin
                s30_next = 31'd1 << 30;
            end else begin
                s30_next = 31'(s_rnd[gcd_pkg::ANGLE_W-1:10]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r0_reg   <= 33'(d_i) + TWO_M;
            r1_reg   <= r1_next;
            r2_reg   <= r2_next;
            fold_reg <= fold_next;
            a_reg    <= prod_rnd[62:22];
            s30_reg  <= s30_next;
            hav_reg  <= 61'(s30_reg) * 61'(s30_reg);
        end
    end

    assign chain[0].x = gcd_pkg::ANGLE_W'(KINV);
    assign chain[0].y = '0;
    assign chain[0].z = gcd_pkg::ANGLE_W'(a_reg);

    for (genvar i = 0; i < STAGES; i++) begin : g_cell
        gcd_sin_cell #(.IDX(i)) u_cell (
            .aclk (aclk),
            .en   (en),
            .c_i  (chain[i]),
            .c_o  (chain[i+1])
        );
    end

    assign hav_o = hav_reg;

endmodule

`default_nettype wire

@@ sv/gcd_sqrt_cell.sv @@
// One digit-by-digit square root cell, two radicand bits per cell.
`default_nettype none

module gcd_sqrt_cell (
    input  wire logic           aclk,
    input  wire logic           en,
    input  wire gcd_pkg::sqrt_t q_i,
    output gcd_pkg::sqrt_t      q_o
);

    logic [35:0] rem_sh;
    logic [35:0] trial;
    gcd_pkg::sqrt_t q_next;
    gcd_pkg::sqrt_t q_reg;

    always_comb begin
        rem_sh     = {q_i.rem, q_i.val[61:60]};
        trial      = 36'({q_i.root, 2'b01});
        q_next.val = {q_i.val[59:0], 2'b00};
        if (rem_sh >= trial) begin
            q_next.rem  = 34'(rem_sh - trial);
            q_next.root = {q_i.root[29:0], 1'b1};
        end else begin
            q_next.rem  = 34'(rem_sh);
            q_next.root = {q_i.root[29:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_next;
        end
    end

    assign q_o = q_reg;

endmodule

`default_nettype wire

@@ sv/gcd_atan_cell.sv @@
// One vectoring-mode CORDIC cell of the arctangent chain.
`default_nettype none

module gcd_atan_cell #(
    parameter int IDX = 0
) (
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire gcd_pkg::cordic_t c_i,
    output gcd_pkg::cordic_t      c_o
);

    localparam logic signed [gcd_pkg::ANGLE_W-1:0] ATAN = gcd_pkg::atan_q40(IDX);

    logic signed [gcd_pkg::ANGLE_W-1:0] dx;
    logic signed [gcd_pkg::ANGLE_W-1:0] dy;
    gcd_pkg::cordic_t c_next;
    gcd_pkg::cordic_t c_reg;

    always_comb begin
        dx = c_i.y >>> IDX;
        dy = c_i.x >>> IDX;
        if (!c_i.y[gcd_pkg::ANGLE_W-1]) begin
            c_next.x = c_i.x + dx;
            c_next.y = c_i.y - dy;
            c_next.z = c_i.z + ATAN;
        end else begin
            c_next.x = c_i.x - dx;
            c_next.y = c_i.y + dy;
            c_next.z = c_i.z - ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_reg <= c_next;
        end
    end

    assign c_o = c_reg;

endmodule

`default_nettype wire

@@ sv/great_circle_distance.sv @@
// Top level of the haversine great-circle distance pipeline.
//
//   channel   direction  ports                                   beat
//   s_        in         s_valid s_ready s_lat_a..s_lon_b        one point pair
//   m_        out        m_valid m_ready m_distance_mm           one distance
//   cfg_      in         cfg_valid cfg_ready cfg_wdata           sphere radius, metres
//
// Every beat passes through a fixed pipeline of 2*CORDIC_STAGES + 48 register
// stages: three sine chains of CORDIC_STAGES cells, two 31-cell square root
// chains and one arctangent chain of CORDIC_STAGES cells. One beat enters per cycle.
// The whole pipeline advances together; it holds only when the output register
// carries a beat that is not taken, and then s_ready is low.
// Reset is synchronous and active low; it empties the pipeline and sets the radius
// to 6371000 m. The configuration channel is always ready.
`default_nettype none

module great_circle_distance #(
    parameter int CORDIC_STAGES = 32
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [29:0] s_lat_a,
    input  wire logic signed [30:0] s_lon_a,
    input  wire logic signed [29:0] s_lat_b,
    input  wire logic signed [30:0] s_lon_b,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [34:0]             m_distance_mm,

    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [22:0]        cfg_wdata
);

    // Lane (7 + N), combine (6), square roots (31), arctangent (N), scaling (4).
    localparam int LAT = 2 * CORDIC_STAGES + 48;

    // Pipeline enable: every stage moves unless a finished beat is stuck at the output.
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // Beat valid flags and the equal-points flag travel alongside the data.
    logic [LAT-1:0] vld_reg;
    logic [LAT-2:0] eq_reg;
    logic           eq_in;

    assign eq_in = (s_lat_a == s_lat_b) && (s_lon_a == s_lon_b);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            eq_reg <= {eq_reg[LAT-3:0], eq_in};
        end
    end

    assign m_valid = vld_reg[LAT-1];

    // Radius register; writes must arrive only while the pipeline is empty; the block does not enforce it.
    logic [22:0] radius_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= gcd_pkg::RADIUS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            radius_reg <= cfg_wdata;
        end
    end

    // The three haversine terms: latitude difference, latitude sum, longitude difference.
    // Each angle in milliarcseconds is read as a half-angle in half-milliarcseconds.
    logic signed [31:0] d_lat;
    logic signed [31:0] s_lat;
    logic signed [31:0] d_lon;
    logic [60:0]        hav_d;
    logic [60:0]        hav_s;
    logic [60:0]        hav_l;

    assign d_lat = 32'(s_lat_b) - 32'(s_lat_a);
    assign s_lat = 32'(s_lat_a) + 32'(s_lat_b);
    assign d_lon = 32'(s_lon_b) - 32'(s_lon_a);

    gcd_hav_lane #(.STAGES(CORDIC_STAGES)) u_lane_dlat (
        .aclk (aclk), .en (en), .d_i (d_lat), .hav_o (hav_d)
    );
    gcd_hav_lane #(.STAGES(CORDIC_STAGES)) u_lane_slat (
        .aclk (aclk), .en (en), .d_i (s_lat), .hav_o (hav_s)
    );
    gcd_hav_lane #(.STAGES(CORDIC_STAGES)) u_lane_dlon (
        .aclk (aclk), .en (en), .d_i (d_lon), .hav_o (hav_l)
    );

    // Combine: h = hav(dlat) + (1 - hav(diff) - hav(sum)) * hav(dlon), the
    // coefficient standing for cos(lat_a)cos(lat_b). It is rounded to Q30 by
    // magnitude and its sign is applied after the product.
    logic signed [61:0] coef_reg;
    logic [60:0]        hd1_reg, hd2_reg, hd3_reg, hd4_reg;
    logic [60:0]        hl1_reg, hl2_reg;
    logic               neg2_reg, neg3_reg, neg4_reg;
    logic [30:0]        c30_reg;
    logic [61:0]        phi_reg;
    logic [60:0]        plo_reg;
    logic [61:0]        term_reg;
    logic [60:0]        h_reg;
    logic [60:0]        hx_reg;
    logic [60:0]        hy_reg;

    logic [61:0]        mag_rnd;
    logic [60:0]        plo_rnd;
    logic signed [62:0] h_sum;
    logic [60:0]        h_next;

    always_comb begin
        if (coef_reg[61]) begin
            mag_rnd = 62'(~coef_reg) + 62'((64'd1 << 29) + 64'd1);
        end else begin
            mag_rnd = 62'(coef_reg) + (62'd1 << 29);
        end
        plo_rnd = plo_reg + (61'd1 << 29);
        if (neg4_reg) begin
            h_sum = $signed(63'(hd4_reg)) - $signed(63'(term_reg));
        end else begin
            h_sum = $signed(63'(hd4_reg)) + $signed(63'(term_reg));
        end
        if (h_sum[62]) begin
            h_next = '0;
        end else if (h_sum > $signed(63'(gcd_pkg::ONE_Q60))) begin
            h_next = gcd_pkg::ONE_Q60;
        end else begin
            h_next = 61'(h_sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            coef_reg <= $signed(62'(gcd_pkg::ONE_Q60)) - $signed(62'(hav_d))
                        - $signed(62'(hav_s));
            hd1_reg  <= hav_d;
            hl1_reg  <= hav_l;

            c30_reg  <= mag_rnd[60:30];
            neg2_reg <= coef_reg[61];
            hd2_reg  <= hd1_reg;
            hl2_reg  <= hl1_reg;

            phi_reg  <= 62'(c30_reg) * 62'(hl2_reg[60:30]);
            plo_reg  <= 61'(c30_reg) * 61'(hl2_reg[29:0]);
            neg3_reg <= neg2_reg;
            hd3_reg  <= hd2_reg;

            term_reg <= phi_reg + 62'(plo_rnd[60:30]);
            neg4_reg <= neg3_reg;
            hd4_reg  <= hd3_reg;

            h_reg    <= h_next;

            hx_reg   <= h_reg;
            hy_reg   <= gcd_pkg::ONE_Q60 - h_reg;
        end
    end

    // Square roots of h and 1 - h, one result bit per cell.
    gcd_pkg::sqrt_t sq_x [32];
    gcd_pkg::sqrt_t sq_y [32];

    assign sq_x[0].val  = 62'(hx_reg);
    assign sq_x[0].rem  = '0;
    assign sq_x[0].root = '0;
    assign sq_y[0].val  = 62'(hy_reg);
    assign sq_y[0].rem  = '0;
    assign sq_y[0].root = '0;

    for (genvar i = 0; i < 31; i++) begin : g_sqrt
        gcd_sqrt_cell u_sqx (.aclk (aclk), .en (en), .q_i (sq_x[i]), .q_o (sq_x[i+1]));
        gcd_sqrt_cell u_sqy (.aclk (aclk), .en (en), .q_i (sq_y[i]), .q_o (sq_y[i+1]));
    end

    // Half the central angle as atan2(sqrt(h), sqrt(1 - h)), in Q40.
    gcd_pkg::cordic_t at_chain [CORDIC_STAGES+1];

    assign at_chain[0].x = gcd_pkg::ANGLE_W'({sq_y[31].root, 10'd0});
    assign at_chain[0].y = gcd_pkg::ANGLE_W'({sq_x[31].root, 10'd0});
    assign at_chain[0].z = '0;

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_atan
        gcd_atan_cell #(.IDX(i)) u_cell (
            .aclk (aclk),
            .en   (en),
            .c_i  (at_chain[i]),
            .c_o  (at_chain[i+1])
        );
    end

    // Scaling: clamp the angle to [0, pi/2], multiply by the radius and by 2000
    // (two half-angles, metres to millimetres), and round away the Q40 fraction.
    logic signed [gcd_pkg::ANGLE_W-1:0] z_out;
    logic [40:0] zc_next;
    logic [40:0] zc_reg;
    logic [63:0] zr_reg;
    logic [35:0] ph_reg;
    logic [51:0] pl_reg;
    logic [34:0] dist_reg;

    assign z_out = at_chain[CORDIC_STAGES].z;

    always_comb begin
        if (z_out[gcd_pkg::ANGLE_W-1]) begin
            zc_next = '0;
        end else if (z_out > $signed(gcd_pkg::ANGLE_W'(gcd_pkg::HALF_PI_Q40))) begin
            zc_next = gcd_pkg::HALF_PI_Q40;
        end else begin
            zc_next = 41'(z_out);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            zc_reg   <= zc_next;
            zr_reg   <= 64'(zc_reg) * 64'(radius_reg);
            ph_reg   <= 36'(zr_reg[63:40]) * 36'd2000;
            pl_reg   <= 52'(zr_reg[39:0]) * 52'd2000 + (52'd1 << 39);
            dist_reg <= eq_reg[LAT-2] ? '0 : 35'(ph_reg + 36'(pl_reg[51:40]));
        end
    end

    assign m_distance_mm = dist_reg;

endmodule

`default_nettype wire

@@ sv/gcd_checker.sv @@
// Port-level checker for the great-circle distance block, with its bind.
`default_nettype none

module gcd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [34:0] m_distance_mm,
    input wire logic        cfg_ready
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_distance_mm))
        else $error("result changed while stalled");

    // A stuck output beat stops the input side.
    a_stall_in: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input accepted while the output was stalled");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // The radius register takes writes at all times outside reset.
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid || !s_valid |-> cfg_ready)
        else $error("configuration channel not ready");

endmodule

bind great_circle_distance gcd_checker u_gcd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_distance_mm (m_distance_mm),
    .cfg_ready     (cfg_ready)
);

`default_nettype wire

@@ tb/great_circle_distance_tb.sv @@
// Self-checking testbench for the haversine great-circle distance pipeline.
`default_nettype none

module great_circle_distance_tb;

    // Number of CORDIC cells per chain in the block and in the predictor.
    localparam int STAGES = 32;
    // The pipeline is 2*STAGES + 48 deep; the settle wait leaves a margin on top.
    localparam int SETTLE_CYCLES = 2 * STAGES + 48 + 40;
    localparam int CYCLE_LIMIT = 2000000;

    localparam longint unsigned PI_Q62_C     = 64'hC90F_DAA2_2168_C235;
    localparam longint          HALF_TURN    = 64'd1296000000;
    localparam longint          QUARTER_TURN = 64'd648000000;
    localparam longint unsigned RAD_STEP_Q62 = (PI_Q62_C + 64'd648000000) / 64'd1296000000;
    localparam longint          RIGHT_Q40    = (PI_Q62_C + (64'd1 << 22)) >> 23;
    localparam longint unsigned UNIT_Q60     = 64'd1 << 60;
    localparam longint unsigned UNIT_Q30     = 64'd1 << 30;
    localparam logic [22:0]     EARTH_M      = 23'd6371000;

    // Coordinate limits in milliarcseconds.
    localparam int LAT_MAX = 324000000;
    localparam int LON_MAX = 648000000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [29:0] s_lat_a = '0;
    logic signed [30:0] s_lon_a = '0;
    logic signed [29:0] s_lat_b = '0;
    logic signed [30:0] s_lon_b = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [34:0]        m_distance_mm;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [22:0]        cfg_wdata = '0;

    great_circle_distance #(
        .CORDIC_STAGES(STAGES)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_lat_a       (s_lat_a),
        .s_lon_a       (s_lon_a),
        .s_lat_b       (s_lat_b),
        .s_lon_b       (s_lon_b),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_distance_mm (m_distance_mm),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_wdata     (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor state: the CORDIC constants, the radius register and the distances
    // still owed by the block, oldest first.
    longint      atan_step_q40 [STAGES];
    longint      inv_gain_q40;
    logic [22:0] radius_m = EARTH_M;
    logic [34:0] distance_due [$];
    int          fail_count = 0;
    int          cycle_count = 0;

    // Sender burst bookkeeping.
    int burst_left = 0;

    // ------------------------------------------------------------------
    // Fixed-point predictor.
    // ------------------------------------------------------------------

    function automatic longint unsigned floor_sqrt(input longint unsigned v_in);
        longint unsigned v;
        longint unsigned res;
        longint unsigned b;
        v   = v_in;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // The arctangent steps come from the odd power series in Q62; the start
    // vector of the sine rotation is the inverse CORDIC gain in Q40.
    task automatic build_cordic_consts();
        longint unsigned v;
        longint unsigned g2;
        longint unsigned g;
        longint unsigned q1;
        longint unsigned r1;
        longint          acc;
        longint          t;
        int              e;
        g2 = 64'd1 << 62;
        for (int i = 0; i < STAGES; i++) begin
            if (i == 0) begin
                v = PI_Q62_C >> 2;
            end else begin
                acc = 0;
                for (int k = 0; k < 64; k++) begin
                    e = 62 - i * (2 * k + 1);
                    if (e < 0) break;
                    t = longint'((64'd1 << e) / longint'(2 * k + 1));
                    acc = (k % 2 == 1) ? acc - t : acc + t;
                end
                v = longint'(acc);
            end
            atan_step_q40[i] = longint'((v + (64'd1 << 21)) >> 22);
            if (2 * i < 64) g2 = g2 + (g2 >> (2 * i));
        end
        g  = floor_sqrt(g2);
        q1 = (64'd1 << 63) / g;
        r1 = (64'd1 << 63) % g;
        inv_gain_q40 = longint'((q1 << 8) + ((r1 << 8) / g));
    endtask

    function automatic longint rotate_sine(input longint angle);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = inv_gain_q40;
        y = 0;
        z = angle;
        for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - atan_step_q40[i];
            end else begin
                x = x + dx; y = y - dy; z = z + atan_step_q40[i];
            end
        end
        return y;
    endfunction

    function automatic longint vector_angle(input longint y_in, input longint x_in);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = x_in;
        y = y_in;
        z = 0;
        for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx; y = y - dy; z = z + atan_step_q40[i];
            end else begin
                x = x - dx; y = y + dy; z = z - atan_step_q40[i];
            end
        end
        return z;
    endfunction

    // sin^2 of half of an angle given in mas; the angle in mas equals the
    // half-angle in half-mas, which is folded into a quarter turn first.
    function automatic longint unsigned haversine_q60(input longint d);
        longint          r;
        longint          s;
        longint unsigned a;
        longint unsigned s30;
        r = d % HALF_TURN;
        if (r < 0) r = r + HALF_TURN;
        if (r > QUARTER_TURN) r = HALF_TURN - r;
        a = (longint'(r) * RAD_STEP_Q62 + (64'd1 << 21)) >> 22;
        s = rotate_sine(longint'(a));
        if (s < 0) s = 0;
        s30 = (longint'(s) + 512) >> 10;
        if (s30 > UNIT_Q30) s30 = UNIT_Q30;
        return s30 * s30;
    endfunction

    function automatic logic [34:0] expected_distance(
        input longint la, input longint oa, input longint lb, input longint ob
    );
        longint unsigned hd;
        longint unsigned hs;
        longint unsigned hl;
        longint unsigned mag;
        longint unsigned c30;
        longint unsigned term;
        longint unsigned xs;
        longint unsigned yc;
        longint unsigned zr;
        longint unsigned dist_mm;
        longint          coef;
        longint          h;
        longint          z;
        if (la == lb && oa == ob) return '0;
        hd = haversine_q60(lb - la);
        hs = haversine_q60(la + lb);
        hl = haversine_q60(ob - oa);
        // cos(lat_a)cos(lat_b) written as 1 - hav(diff) - hav(sum); may go negative.
        coef = longint'(UNIT_Q60) - longint'(hd) - longint'(hs);
        mag  = longint'(coef < 0 ? -coef : coef);
        c30  = (mag + (64'd1 << 29)) >> 30;
        term = c30 * (hl >> 30) + ((c30 * (hl & (UNIT_Q30 - 1)) + (64'd1 << 29)) >> 30);
        h = (coef < 0) ? longint'(hd) - longint'(term) : longint'(hd) + longint'(term);
        if (h < 0) h = 0;
        if (h > longint'(UNIT_Q60)) h = longint'(UNIT_Q60);
        xs = floor_sqrt(longint'(h));
        yc = floor_sqrt(UNIT_Q60 - longint'(h));
        z  = vector_angle(longint'(xs << 10), longint'(yc << 10));
        if (z < 0) z = 0;
        if (z > RIGHT_Q40) z = RIGHT_Q40;
        zr   = longint'(z) * longint'(radius_m);
        dist_mm = (zr >> 40) * 2000
                + (((zr & ((64'd1 << 40) - 1)) * 2000 + (64'd1 << 39)) >> 40);
        return dist_mm[34:0];
    endfunction

    // ------------------------------------------------------------------
    // Monitor: the radius and the owed distances follow the accepted beats.
    // Every signal is read at the rising edge, before that edge's updates land.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("great_circle_distance_tb NOT OK");
            $finish;
        end else if (aresetn) begin
            if (m_valid && m_ready) begin
                if (distance_due.size() == 0) begin
                    $display("%0t: unexpected distance beat, actual %0d", $time, m_distance_mm);
                    fail_count++;
                end else begin
                    if (m_distance_mm !== distance_due[0]) begin
                        $display("%0t: distance_mm expected %0d actual %0d",
                                 $time, distance_due[0], m_distance_mm);
                        fail_count++;
                    end
                    void'(distance_due.pop_front());
                end
            end
            if (cfg_valid && cfg_ready) radius_m = cfg_wdata;
            if (s_valid && s_ready)
                distance_due.push_back(expected_distance(s_lat_a, s_lon_a, s_lat_b, s_lon_b));
        end
    end

    // The receiver steps through four stall patterns as the cycle count grows: always
    // ready, coin flips, periodic one-cycle ready pulses, and rare long stalls.
    always @(posedge aclk) begin
        case (cycle_count[9:8])
            2'd0: begin
                m_ready <= 1'b1;
            end
            2'd1: begin
                m_ready <= 1'($urandom_range(1));
            end
            2'd2: begin
                m_ready <= (cycle_count[1:0] == 2'd0);
            end
            default: begin
                m_ready <= (cycle_count[5:3] != 3'd0);
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Shared stimulus tasks.
    // ------------------------------------------------------------------

    // Sends one point pair and waits until it is accepted. Valid stays high into the
    // next pair while a burst lasts; between bursts it drops for a random gap.
    task automatic send_pair(input logic signed [29:0] la, input logic signed [30:0] oa,
                             input logic signed [29:0] lb, input logic signed [30:0] ob);
        s_valid <= 1'b1;
        s_lat_a <= la;
        s_lon_a <= oa;
        s_lat_b <= lb;
        s_lon_b <= ob;
        do @(posedge aclk); while (!s_ready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(0, 40);
        end
    endtask

    // Holds the sender until every owed distance is in, then lets the pipeline settle.
    task automatic drain_pipeline();
        s_valid <= 1'b0;
        while (distance_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_radius(input logic [22:0] r);
        cfg_valid <= 1'b1;
        cfg_wdata <= r;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic signed [29:0] rand_lat();
        return 30'(int'($urandom_range(2 * LAT_MAX)) - LAT_MAX);
    endfunction

    function automatic logic signed [30:0] rand_lon();
        return 31'(int'($urandom_range(2 * LON_MAX)) - LON_MAX);
    endfunction

    // Mostly legal coordinates, with a share of raw full-width values so that
    // every input bit toggles and out-of-range angles are exercised.
    task automatic send_random_pair();
        logic signed [29:0] la;
        logic signed [30:0] oa;
        logic signed [29:0] lb;
        logic signed [30:0] ob;
        int                 pick;
        pick = $urandom_range(99);
        la = rand_lat(); oa = rand_lon(); lb = rand_lat(); ob = rand_lon();
        if (pick < 10) begin
            la = 30'($urandom()); oa = 31'($urandom());
            lb = 30'($urandom()); ob = 31'($urandom());
        end else if (pick < 15) begin
            lb = la; ob = oa;
        end else if (pick < 45) begin
            // A short hop as seen on a GPS track.
            lb = la + 30'(int'($urandom_range(20000)) - 10000);
            ob = oa + 31'(int'($urandom_range(20000)) - 10000);
        end else if (pick < 55) begin
            // Close to the antipode, where h nears one and sqrt(1 - h) is steep.
            lb = -la + 30'(int'($urandom_range(2000)) - 1000);
            ob = oa + 31'(LON_MAX) + 31'(int'($urandom_range(2000)) - 1000);
        end
        send_pair(la, oa, lb, ob);
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Field extremes, equal points, poles, antipodes and the date line.
    task automatic test_directed();
        send_pair(30'sd0, 31'sd0, 30'sd0, 31'sd0);
        send_pair(30'sd12345678, -31'sd87654321, 30'sd12345678, -31'sd87654321);
        send_pair(30'sd324000000, 31'sd0, -30'sd324000000, 31'sd0);
        send_pair(30'sd0, 31'sd0, 30'sd0, 31'sd648000000);
        send_pair(30'sd0, -31'sd648000000, 30'sd0, 31'sd648000000);
        send_pair(30'sd1, 31'sd0, 30'sd0, 31'sd0);
        send_pair(30'sd0, 31'sd1, 30'sd0, 31'sd0);
        send_pair(30'sd324000000, 31'sd100, 30'sd324000000, -31'sd5000000);
        send_pair(30'sd162000000, 31'sd0, -30'sd162000000, 31'sd648000000);
        send_pair(30'sd162000000, 31'sd10, -30'sd162000000, 31'sd647999990);
        send_pair(-30'sd536870912, -31'sd1073741824, 30'sd536870911, 31'sd1073741823);
        send_pair(30'sd536870911, 31'sd1073741823, -30'sd536870912, -31'sd1073741824);
        send_pair(-30'sd536870912, 31'sd1073741823, -30'sd536870912, -31'sd1073741824);
        send_pair(-30'sd1, -31'sd1, 30'sd0, 31'sd0);
        send_pair(30'sd180000000, 31'sd90000000, -30'sd180000000, -31'sd90000000);
        send_pair(30'sd0, 31'sd324000000, 30'sd0, -31'sd324000000);
        drain_pipeline();
    endtask

    // Radius extremes: zero, range bounds, full register width, and back to Earth.
    task automatic test_radius_settings();
        logic [22:0] radii [6];
        radii = '{23'd0, 23'd1000000, 23'd8000000, 23'h7F_FFFF, 23'd1, EARTH_M};
        foreach (radii[n]) begin
            write_radius(radii[n]);
            send_pair(30'sd0, 31'sd0, 30'sd0, 31'sd648000000);
            send_pair(30'sd324000000, 31'sd0, -30'sd324000000, 31'sd0);
            repeat (40) send_random_pair();
            drain_pipeline();
        end
    endtask

    task automatic test_random_tracks();
        for (int n = 0; n < 1400; n++) begin
            send_random_pair();
            // An occasional full stop until the pipeline is empty.
            if (n % 500 == 250) drain_pipeline();
        end
        drain_pipeline();
    endtask

    initial begin
        build_cordic_consts();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_radius_settings();
        test_random_tracks();
        if (fail_count == 0) begin
            $display("great_circle_distance_tb OK");
        end else begin
            $display("great_circle_distance_tb NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
